// ===== hdl/bfifo_pkg.sv =====
package bfifo_pkg;

	localparam int STORE_DEPTH    = 4096;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int LEN_W          = 13;
	localparam int BYTE_W         = 8;
	localparam int MAX_READ_BURST = 64;
	localparam int RCNT_W         = $clog2(MAX_READ_BURST + 1);
	localparam int PCT_W          = 7;
	localparam int PCT_SCALE      = 100;
	// dividend = fill * 100, below 2^(LEN_W + PCT_W - 1)
	localparam int DIV_W          = LEN_W + PCT_W - 1;
	localparam int STEP_W         = $clog2(PCT_W);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RESULT,
		ST_READ
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [LEN_W-1:0]  request_length;
		logic [BYTE_W-1:0] data_byte;
		logic              first_of_burst;
		logic              last_of_burst;
	} req_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic [LEN_W-1:0]  done_length;
		logic              last_result;
		logic [LEN_W-1:0]  fill_count;
		logic [LEN_W-1:0]  free_count;
		logic [PCT_W-1:0]  fill_percent;
	} rsp_item_t;

endpackage

// ===== hdl/bfifo_ram.sv =====
module bfifo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/bfifo_pct.sv =====
// fill * 100 / capacity, one quotient bit per cycle (quotient never exceeds 100)
module bfifo_pct (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bfifo_pkg::LEN_W-1:0] fill,
	input  logic [bfifo_pkg::LEN_W-1:0] cap,
	output logic                      done,
	output logic [bfifo_pkg::PCT_W-1:0] pct
);
	import bfifo_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [PCT_W-1:0]  quo_q;
	logic              zero_q;
	logic              ge;

	assign ge   = rem_q >= dsh_q;
	assign done = busy_q && (cnt_q == '0);
	assign pct  = zero_q ? '0 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(PCT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DIV_W'(fill) * DIV_W'(PCT_SCALE);
			dsh_q  <= DIV_W'(cap) << (PCT_W - 1);
			quo_q  <= '0;
			zero_q <= (cap == '0);
		end else if (busy_q) begin
			rem_q <= ge ? (rem_q - dsh_q) : rem_q;
			quo_q <= {quo_q[PCT_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

// ===== hdl/byte_ring_fifo_all_or_nothing_top.sv =====
// Circular byte FIFO with all-or-nothing write bursts. The bytes live in one
// 4096 x 8 synchronous RAM; pointers, fill count and burst state are flops.
// Writing cfg_data (capacity, saturated to 4096) empties the ring; write it only
// while the block is idle. A write item stores its byte in the cycle it is taken
// and the next item is taken in the following cycle, so bursts stream at one
// byte per cycle. The first byte carries the burst length; the burst is kept
// only if it fits the free space at that moment. The last byte of a burst, a
// clear, and a read or peek each produce results: the fill percentage is worked
// out by a shared shift-subtract divider, one quotient bit a cycle; the single
// result of a last write, a clear or an empty read or peek follows the divider
// and the next item is taken in the cycle after that result enters the output
// register. A read or peek of n bytes (n capped at 64) waits for the divider,
// then streams one byte per cycle through the RAM read port as long as
// rsp_stall stays low; the next item is taken in the cycle after the last
// byte enters the output register. Every result shows the fill count after the
// request.
module byte_ring_fifo_all_or_nothing_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [bfifo_pkg::LEN_W-1:0]    cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  bfifo_pkg::req_item_t           req_item,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output bfifo_pkg::rsp_item_t           rsp_item
);
	import bfifo_pkg::*;

	state_t            state_q, state_d;

	// ring state
	logic [LEN_W-1:0]  cap_q;
	logic [ADDR_W-1:0] rp_q, wp_q;
	logic [LEN_W-1:0]  stored_q;
	logic              bacc_q;
	logic [LEN_W-1:0]  blen_q, bwr_q;

	// per-request registers
	logic [LEN_W-1:0]  done_q;
	logic [RCNT_W-1:0] nrd_q, rcnt_q;
	logic [ADDR_W-1:0] rptr_q;

	logic              rsp_valid_q;
	rsp_item_t         rsp_item_q;

	// datapath
	logic              accept;
	logic [LEN_W-1:0]  free_now;
	logic              burst_ok, bacc_eff, do_store;
	logic [LEN_W-1:0]  blen_eff, bwr_eff, wr_done;
	logic [LEN_W-1:0]  wp_inc, n_lim, rp_sum, rp_adv, rptr_inc, stored_d;
	logic [ADDR_W-1:0] wp_next, rptr_next;
	logic [RCNT_W-1:0] n_rd;
	logic              rd_last;

	// control
	logic              rsp_free, rsp_load;
	logic              ram_re, div_start, div_done;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic [PCT_W-1:0]  pct;

	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	always_comb begin
		free_now = cap_q - stored_q;
		burst_ok = (req_item.request_length != '0) && (req_item.request_length <= free_now);
		bacc_eff = req_item.first_of_burst ? burst_ok : bacc_q;
		blen_eff = req_item.first_of_burst ? req_item.request_length : blen_q;
		bwr_eff  = req_item.first_of_burst ? '0 : bwr_q;
		do_store = bacc_eff && (bwr_eff < blen_eff) && (stored_q < cap_q);
		wr_done  = bacc_eff ? (bwr_eff + LEN_W'(do_store)) : '0;

		wp_inc   = LEN_W'(wp_q) + 1'b1;
		wp_next  = (wp_inc >= cap_q) ? '0 : wp_inc[ADDR_W-1:0];

		// bytes returned: min(request, stored, 64)
		n_lim    = (req_item.request_length < stored_q) ? req_item.request_length : stored_q;
		n_rd     = (n_lim > LEN_W'(MAX_READ_BURST)) ? RCNT_W'(MAX_READ_BURST)
		                                            : n_lim[RCNT_W-1:0];
		rp_sum   = LEN_W'(rp_q) + LEN_W'(n_rd);
		rp_adv   = (rp_sum >= cap_q) ? (rp_sum - cap_q) : rp_sum;

		rptr_inc  = LEN_W'(rptr_q) + 1'b1;
		rptr_next = (rptr_inc >= cap_q) ? '0 : rptr_inc[ADDR_W-1:0];
		rd_last   = (rcnt_q + 1'b1) == nrd_q;

		case (req_item.operation)
			OP_WRITE: stored_d = stored_q + LEN_W'(do_store);
			OP_READ:  stored_d = stored_q - LEN_W'(n_rd);
			OP_PEEK:  stored_d = stored_q;
			OP_CLEAR: stored_d = '0;
			default:  stored_d = stored_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_item.operation != OP_WRITE || req_item.last_of_burst) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (nrd_q != '0) ? ST_READ : ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (rsp_free && rd_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall = 1'b1;
		div_start = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rptr_q;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				// stall is low here, so valid alone means the item is taken
				div_start = req_valid &&
				            (req_item.operation != OP_WRITE || req_item.last_of_burst);
			end
			ST_DIV: begin
				ram_re = div_done && (nrd_q != '0);
			end
			ST_RESULT: begin
				rsp_load = rsp_free;
			end
			ST_READ: begin
				rsp_load  = rsp_free;
				ram_re    = rsp_free && !rd_last;
				ram_raddr = rptr_next;
			end
			default: ;
		endcase
	end

	bfifo_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept && (req_item.operation == OP_WRITE) && do_store),
		.waddr(wp_q),
		.wdata(req_item.data_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bfifo_pct u_pct (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.fill  (stored_d),
		.cap   (cap_q),
		.done  (div_done),
		.pct   (pct)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			stored_q    <= '0;
			bacc_q      <= 1'b0;
			blen_q      <= '0;
			bwr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_write_en) begin
				cap_q    <= (cfg_data > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : cfg_data;
				rp_q     <= '0;
				wp_q     <= '0;
				stored_q <= '0;
				bacc_q   <= 1'b0;
				blen_q   <= '0;
				bwr_q    <= '0;
			end else if (accept) begin
				stored_q <= stored_d;
				case (req_item.operation)
					OP_WRITE: begin
						if (do_store) begin
							wp_q <= wp_next;
						end
						if (req_item.last_of_burst) begin
							bacc_q <= 1'b0;
							blen_q <= '0;
							bwr_q  <= '0;
						end else begin
							bacc_q <= bacc_eff;
							blen_q <= blen_eff;
							bwr_q  <= bwr_eff + LEN_W'(do_store);
						end
					end
					OP_READ: begin
						rp_q <= rp_adv[ADDR_W-1:0];
					end
					OP_PEEK: ;
					OP_CLEAR: begin
						rp_q   <= '0;
						wp_q   <= '0;
						bacc_q <= 1'b0;
						blen_q <= '0;
						bwr_q  <= '0;
					end
					default: ;
				endcase
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// per-request payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			done_q <= (req_item.operation == OP_WRITE) ? wr_done : '0;
			nrd_q  <= (req_item.operation == OP_READ || req_item.operation == OP_PEEK)
			          ? n_rd : '0;
			rcnt_q <= '0;
			rptr_q <= rp_q;
		end else if (state_q == ST_READ && rsp_load) begin
			rcnt_q <= rcnt_q + 1'b1;
			rptr_q <= rptr_next;
		end

		if (rsp_load) begin
			rsp_item_q.fill_count   <= stored_q;
			rsp_item_q.free_count   <= cap_q - stored_q;
			rsp_item_q.fill_percent <= pct;
			if (state_q == ST_READ) begin
				rsp_item_q.out_byte    <= ram_rdata;
				rsp_item_q.byte_valid  <= 1'b1;
				rsp_item_q.done_length <= LEN_W'(nrd_q);
				rsp_item_q.last_result <= rd_last;
			end else begin
				rsp_item_q.out_byte    <= '0;
				rsp_item_q.byte_valid  <= 1'b0;
				rsp_item_q.done_length <= done_q;
				rsp_item_q.last_result <= 1'b1;
			end
		end
	end

endmodule

// ===== dv/bfifo_checker.sv =====
module bfifo_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [bfifo_pkg::LEN_W-1:0] cfg_data,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  bfifo_pkg::req_item_t        req_item,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  bfifo_pkg::rsp_item_t        rsp_item,
	output int                          mismatches,
	output int                          pending,
	output int                          checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import bfifo_pkg::*;

	// shadow ring state
	logic [BYTE_W-1:0] ring_mem [STORE_DEPTH];
	int unsigned       capacity;
	int unsigned       rd_ptr;
	int unsigned       wr_ptr;
	int unsigned       fill;
	bit                burst_kept;
	int unsigned       burst_len;
	int unsigned       burst_cnt;

	rsp_item_t         expected_rsp_q[$];
	int                bad_count;
	int                good_count;

	function automatic int unsigned ring_inc(input int unsigned p);
		return (p + 1 >= capacity) ? 0 : p + 1;
	endfunction

	function automatic string rsp_text(input rsp_item_t r);
		return $sformatf("byte=%0d vld=%0d done=%0d last=%0d fill=%0d free=%0d pct=%0d",
			r.out_byte, r.byte_valid, r.done_length, r.last_result,
			r.fill_count, r.free_count, r.fill_percent);
	endfunction

	task automatic empty_ring();
		rd_ptr     = 0;
		wr_ptr     = 0;
		fill       = 0;
		burst_kept = 1'b0;
		burst_len  = 0;
		burst_cnt  = 0;
	endtask

	// status fields always reflect the ring after the whole item
	task automatic push_expected(input logic [BYTE_W-1:0] b, input bit vld,
		input int unsigned done, input bit is_last);
		rsp_item_t r;
		r.out_byte     = b;
		r.byte_valid   = vld;
		r.done_length  = LEN_W'(done);
		r.last_result  = is_last;
		r.fill_count   = LEN_W'(fill);
		r.free_count   = LEN_W'(capacity - fill);
		r.fill_percent = (capacity == 0) ? '0 : PCT_W'((fill * PCT_SCALE) / capacity);
		expected_rsp_q.push_back(r);
	endtask

	task automatic predict_fifo_step(input req_item_t it);
		int unsigned       n;
		int unsigned       p;
		int unsigned       len;
		logic [BYTE_W-1:0] got [MAX_READ_BURST];
		len = it.request_length;
		case (it.operation)
		OP_WRITE: begin
			if (it.first_of_burst) begin
				burst_len  = len;
				burst_cnt  = 0;
				burst_kept = (len != 0) && (len <= capacity - fill);
			end
			if (burst_kept && burst_cnt < burst_len && fill < capacity) begin
				ring_mem[wr_ptr] = it.data_byte;
				wr_ptr = ring_inc(wr_ptr);
				fill++;
				burst_cnt++;
			end
			if (it.last_of_burst) begin
				push_expected('0, 1'b0, burst_kept ? burst_cnt : 0, 1'b1);
				burst_kept = 1'b0;
				burst_len  = 0;
				burst_cnt  = 0;
			end
		end
		OP_CLEAR: begin
			empty_ring();
			push_expected('0, 1'b0, 0, 1'b1);
		end
		default: begin
			n = len;
			if (n > fill) n = fill;
			if (n > MAX_READ_BURST) n = MAX_READ_BURST;
			if (n == 0) begin
				push_expected('0, 1'b0, 0, 1'b1);
			end else begin
				p = rd_ptr;
				for (int i = 0; i < n; i++) begin
					got[i] = ring_mem[p];
					p = ring_inc(p);
				end
				if (it.operation == OP_READ) begin
					rd_ptr = p;
					fill   = fill - n;
				end
				for (int i = 0; i < n; i++)
					push_expected(got[i], 1'b1, n, i + 1 == n);
			end
		end
		endcase
	endtask

	task automatic check_rsp(input rsp_item_t act);
		rsp_item_t want;
		bit        ok;
		if (expected_rsp_q.size() == 0) begin
			bad_count++;
			if (bad_count <= 10)
				$display("ERROR: result with nothing expected: %s", rsp_text(act));
			return;
		end
		want = expected_rsp_q.pop_front();
		good_count++;
		ok = (act.out_byte === want.out_byte) && (act.byte_valid === want.byte_valid) &&
			(act.done_length === want.done_length) &&
			(act.last_result === want.last_result) &&
			(act.fill_count === want.fill_count) && (act.free_count === want.free_count) &&
			(act.fill_percent === want.fill_percent);
		if (!ok) begin
			bad_count++;
			if (bad_count <= 10)
				$display("ERROR: result mismatch\n  expected %s\n  actual   %s",
					rsp_text(want), rsp_text(act));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = 0;
			empty_ring();
			expected_rsp_q.delete();
			bad_count  = 0;
			good_count = 0;
			mismatches <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_rsp(rsp_item);
			if (cfg_write_en) begin
				capacity = (cfg_data > STORE_DEPTH) ? STORE_DEPTH : cfg_data;
				empty_ring();
			end
			if (req_valid && !req_stall)
				predict_fifo_step(req_item);
			mismatches <= bad_count;
			pending    <= expected_rsp_q.size();
			checked    <= good_count;
		end
	end

endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfifo_pkg::*;

	// quiet time after the last expected result: a non-last write byte has no
	// result, so give the block time to finish storing it
	localparam int SETTLE_CYCLES = 16;
	// tail wait at the end: covers the longest read, divider setup plus 64 bytes
	localparam int END_CYCLES    = 100;
	// cycles with no item moving and no register write before the run is declared hung
	localparam int IDLE_LIMIT    = 2000;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 24;

	logic             clk;
	logic             arst_n;
	logic             cfg_write_en;
	logic [LEN_W-1:0] cfg_data;
	logic             req_valid;
	logic             req_stall;
	req_item_t        req_item;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_item_t        rsp_item;

	int               mismatches;
	int               pending;
	int               checked;

	bit               quiet;        // no gaps and no stalls while set
	int               n_items;
	int               n_cfg;
	int               stuck_cycles;

	byte_ring_fifo_all_or_nothing_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_item     (req_item),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_item     (rsp_item)
	);

	// predicts every result from the accepted items and compares in order
	bfifo_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_item     (req_item),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_item     (rsp_item),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hang detector: counts cycles in which no item moves on either channel
	// and no register write happens.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write_en)
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Result side: before each item hold stall at random (never while quiet), then drop it
	// and wait for the item to be taken.
	initial begin
		int hold;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 6);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(rsp_valid && !rsp_stall));
		end
	end

	// One item on the request channel, after a random gap. The payload is set
	// together with valid and stays put until the item is taken.
	task automatic send_item(input op_t op, input int unsigned len,
		input logic [BYTE_W-1:0] data, input bit is_first, input bit is_last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= '{operation: op, request_length: LEN_W'(len), data_byte: data,
			first_of_burst: is_first, last_of_burst: is_last};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		n_items++;
	endtask

	// Write burst: the announced length rides on the first byte only; the
	// length field of later bytes is noise the block must ignore.
	task automatic send_burst(input int unsigned len, input int unsigned nb,
		input bit has_last);
		for (int i = 0; i < nb; i++)
			send_item(OP_WRITE, (i == 0) ? len : $urandom_range(0, 8191),
				BYTE_W'($urandom_range(0, 255)), i == 0, has_last && (i == nb - 1));
	endtask

	// Stop sending until every expected result is back, then hold off.
	// The first edge lets the checker see the last accepted item.
	task automatic drain(input int hold);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (hold) @(posedge clk);
	endtask

	// Capacity changes only on an idle block.
	task automatic write_capacity(input int unsigned value);
		drain(SETTLE_CYCLES);
		cfg_write_en <= 1'b1;
		cfg_data     <= LEN_W'(value);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		n_cfg++;
	endtask

	// One random request sequence. Half are write bursts, mostly well formed
	// and sized to the ring; the rest are reads, peeks, clears and noise.
	task automatic random_sequence(input int unsigned cap);
		int unsigned lim;
		int unsigned len;
		int unsigned nb;
		int unsigned pick;
		bit          has_last;
		lim  = (cap == 0) ? 1 : ((cap < 24) ? cap : 24);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			has_last = 1'b1;
			case ($urandom_range(0, 9))
			0: len = 0;                                  // zero-length, refused
			1: len = $urandom_range(0, 8191);            // usually oversized
			2: len = cap + $urandom_range(1, 3);         // can never fit
			default: len = $urandom_range(1, lim);
			endcase
			// bursts longer than 24 bytes are cut short: most are refused anyway
			nb = (len >= 1 && len <= 24) ? len : $urandom_range(1, 4);
			case ($urandom_range(0, 9))
			0: nb = nb + $urandom_range(1, 2);           // bytes past the length
			1: if (nb > 1) nb = nb - 1;                  // last mark comes early
			2: has_last = 1'b0;                          // next first reopens
			default: ;
			endcase
			send_burst(len, nb, has_last);
		end else if (pick < 75) begin
			send_item(pick[0] ? OP_READ : OP_PEEK,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 70),
				BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (pick < 80) begin
			send_item(OP_CLEAR, $urandom_range(0, 8191), BYTE_W'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			// any field, any value: stray write bytes, stray marks
			send_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 8191),
				BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		// capacity plan per random phase: extremes, saturation, odd sizes;
		// the last phase draws a value over the whole register range
		int unsigned cap_plan [PHASES];
		int unsigned cap;
		int          phase_start;

		cap_plan     = '{1, 7, 8191, 37, 3, 4096, 100, 0, 16, 4095, 64, 13};
		arst_n       <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_data     <= '0;
		req_valid    <= 1'b0;
		req_item     <= '0;
		quiet        = 1'b0;
		n_items      = 0;
		n_cfg        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// capacity is 0 out of reset: reads find nothing, bursts are refused
		send_item(OP_READ, 5, 8'h00, 1'b0, 1'b0);
		send_item(OP_WRITE, 1, 8'hFF, 1'b1, 1'b1);
		send_item(OP_CLEAR, 0, 8'h00, 1'b0, 1'b0);

		write_capacity(5);
		send_burst(5, 5, 1'b1);                        // fills the ring exactly
		send_item(OP_WRITE, 1, 8'h00, 1'b1, 1'b1);     // full: refused
		send_item(OP_READ, 2, 8'h00, 1'b0, 1'b0);
		send_burst(2, 3, 1'b1);                        // wraps; third byte dropped
		send_item(OP_PEEK, 8191, 8'h00, 1'b0, 1'b0);   // capped, reads across the wrap
		send_item(OP_WRITE, 0, 8'h5A, 1'b0, 1'b1);     // last mark with no open burst
		send_item(OP_READ, 0, 8'h00, 1'b0, 1'b0);      // zero request
		send_item(OP_WRITE, 0, 8'hA5, 1'b1, 1'b1);     // zero-length burst refused
		send_item(OP_READ, 64, 8'h00, 1'b0, 1'b0);     // more than stored
		send_item(OP_READ, 64, 8'h00, 1'b0, 1'b0);     // now empty
		send_burst(3, 1, 1'b0);                        // open burst, one byte kept
		send_burst(2, 2, 1'b1);                        // new first restarts the burst
		send_item(OP_CLEAR, 0, 8'h00, 1'b0, 1'b0);

		// --- random part ---
		// every fourth phase runs without gaps or stalls on either side
		for (int ph = 0; ph < PHASES; ph++) begin
			cap = (ph == PHASES - 1) ? $urandom_range(0, 8191) : cap_plan[ph];
			write_capacity(cap);
			quiet       = (ph % 4 == 2);
			phase_start = n_items;
			while (n_items - phase_start < PHASE_ITEMS) begin
				random_sequence((cap > STORE_DEPTH) ? STORE_DEPTH : cap);
				// now and then let the result side run dry mid-phase
				if ($urandom_range(0, 39) == 0)
					drain(0);
			end
		end
		quiet = 1'b0;

		drain(END_CYCLES);
		$display("Covered %0d request items over %0d capacity settings, %0d results checked",
			n_items, n_cfg, checked);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
